### rtl/pfs_pkg.sv
// Shared types and constants for the playback frame sequencer.
// Depends on nothing; used by every module of the block.
package pfs_pkg;

    localparam int unsigned NUM_REGS   = 5;
    localparam int unsigned PADDR_W    = 5;
    localparam logic [16:0] MAX_FRAMES = 17'd65536;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_FRAME_COUNT     = 3'd0;
    localparam logic [2:0] REG_LOOP_START      = 3'd1;
    localparam logic [2:0] REG_LOOP_END        = 3'd2;
    localparam logic [2:0] REG_BOUND_MODE      = 3'd3;
    localparam logic [2:0] REG_TICKS_PER_FRAME = 3'd4;

    // Event opcodes
    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_PLAY   = 3'd1;
    localparam logic [2:0] OP_PAUSE  = 3'd2;
    localparam logic [2:0] OP_RESUME = 3'd3;
    localparam logic [2:0] OP_STOP   = 3'd4;
    localparam logic [2:0] OP_SEEK   = 3'd5;
    localparam logic [2:0] OP_DIR    = 3'd6;

    // Loop modes; the fourth code keeps the stepped frame
    localparam logic [1:0] LM_NORMAL = 2'd0;
    localparam logic [1:0] LM_WRAP   = 2'd1;
    localparam logic [1:0] LM_PING   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE    = 2'd0,
        ST_PLAYING = 2'd1,
        ST_PAUSED  = 2'd2,
        ST_STOPPED = 2'd3
    } player_state_t;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [15:0] target_frame;
        logic        forwards;
    } in_word_t;

    typedef struct packed {
        logic [15:0] frame_index;
        logic        fetch_frame;
        logic        loop_hit;
        logic        error_flag;
        logic [1:0]  player_state;
        logic        going_forward;
    } out_word_t;

    typedef struct packed {
        logic [16:0] frame_count;
        logic [15:0] loop_start;
        logic [15:0] loop_end;
        logic [1:0]  bound_mode;
        logic [31:0] ticks_per_frame;
    } cfg_t;

    typedef struct packed {
        player_state_t mode;
        logic [15:0]   frame;
        logic          fwd;
        logic [31:0]   countdown;
    } pstate_t;

endpackage

### rtl/pfs_regs.sv
// APB configuration register file for the frame sequencer.
// Depends on pfs_pkg for the register indexes and cfg_t.
module pfs_regs
    import pfs_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t       cfg_reg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_count     <= 17'd1;
            cfg_reg.loop_start      <= '0;
            cfg_reg.loop_end        <= '0;
            cfg_reg.bound_mode      <= LM_NORMAL;
            cfg_reg.ticks_per_frame <= 32'd1;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_FRAME_COUNT:     cfg_reg.frame_count     <= pwdata[16:0];
                REG_LOOP_START:      cfg_reg.loop_start      <= pwdata[15:0];
                REG_LOOP_END:        cfg_reg.loop_end        <= pwdata[15:0];
                REG_BOUND_MODE:      cfg_reg.bound_mode      <= pwdata[1:0];
                REG_TICKS_PER_FRAME: cfg_reg.ticks_per_frame <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_FRAME_COUNT:     prdata = {15'd0, cfg_reg.frame_count};
            REG_LOOP_START:      prdata = {16'd0, cfg_reg.loop_start};
            REG_LOOP_END:        prdata = {16'd0, cfg_reg.loop_end};
            REG_BOUND_MODE:      prdata = {30'd0, cfg_reg.bound_mode};
            REG_TICKS_PER_FRAME: prdata = cfg_reg.ticks_per_frame;
            default:             prdata = '0;
        endcase
    end

endmodule

### rtl/pfs_step.sv
// Next-state and result logic for one event word.
// Depends on pfs_pkg; purely combinational.
module pfs_step
    import pfs_pkg::*;
(
    input  cfg_t      cfg,
    input  pstate_t   cur,
    input  in_word_t  word,
    output pstate_t   nxt,
    output out_word_t res
);

    logic [16:0] fwd_next;
    logic [15:0] rev_next;
    logic [15:0] stepped;
    logic        boundary;
    logic        fetch;
    logic        hit;
    logic        err;

    // Single frame step and loop-range edge test
    always_comb begin
        fwd_next = {1'b0, cur.frame} + 17'd1;
        rev_next = cur.frame - 16'd1;
        if (cur.fwd) begin
            stepped  = fwd_next[15:0];
            boundary = fwd_next >= {1'b0, cfg.loop_end};
        end else begin
            stepped  = rev_next;
            boundary = (cur.frame == 16'd0) || (rev_next <= cfg.loop_start);
        end
    end

    always_comb begin
        nxt   = cur;
        fetch = 1'b0;
        hit   = 1'b0;
        err   = 1'b0;
        unique case (word.opcode)
            OP_TICK: begin
                if (cur.mode == ST_PLAYING) begin
                    if (cur.countdown > 32'd1) begin
                        nxt.countdown = cur.countdown - 32'd1;
                    end else if (!boundary) begin
                        nxt.frame     = stepped;
                        nxt.countdown = cfg.ticks_per_frame;
                        fetch         = 1'b1;
                    end else begin
                        hit = 1'b1;
                        unique case (cfg.bound_mode)
                            LM_NORMAL: begin
                                nxt.mode      = ST_STOPPED;
                                nxt.frame     = cfg.loop_start;
                                nxt.countdown = cfg.ticks_per_frame;
                                fetch         = 1'b1;
                            end
                            LM_WRAP: begin
                                nxt.frame     = cur.fwd ? cfg.loop_start : cfg.loop_end;
                                nxt.countdown = cfg.ticks_per_frame;
                                fetch         = 1'b1;
                            end
                            LM_PING: begin
                                nxt.frame     = cur.fwd ? cfg.loop_end : cfg.loop_start;
                                nxt.fwd       = !cur.fwd;
                                nxt.countdown = cfg.ticks_per_frame;
                                fetch         = 1'b1;
                            end
                            // unknown mode: keep stepped frame, retry next tick
                            default: nxt.frame = stepped;
                        endcase
                    end
                end
            end
            OP_PLAY: begin
                if (cur.mode == ST_PLAYING) begin
                    err = 1'b1;
                end else begin
                    nxt.countdown = cfg.ticks_per_frame;
                    nxt.mode      = ST_PLAYING;
                end
            end
            OP_PAUSE: begin
                if (cur.mode != ST_PLAYING) err = 1'b1;
                else nxt.mode = ST_PAUSED;
            end
            OP_RESUME: begin
                if (cur.mode != ST_PAUSED) begin
                    err = 1'b1;
                end else begin
                    nxt.countdown = cfg.ticks_per_frame;
                    nxt.mode      = ST_PLAYING;
                end
            end
            OP_STOP: begin
                if (cur.mode != ST_PLAYING && cur.mode != ST_PAUSED) begin
                    err = 1'b1;
                end else begin
                    nxt.mode  = ST_STOPPED;
                    nxt.frame = cfg.loop_start;
                    fetch     = 1'b1;
                end
            end
            OP_SEEK: begin
                if (({1'b0, word.target_frame} >= cfg.frame_count) ||
                    ({1'b0, word.target_frame} >= MAX_FRAMES)) begin
                    err = 1'b1;
                end else begin
                    nxt.frame     = word.target_frame;
                    nxt.countdown = cfg.ticks_per_frame;
                    fetch         = 1'b1;
                end
            end
            OP_DIR:  nxt.fwd = word.forwards;
            default: err = 1'b1;
        endcase
    end

    always_comb begin
        res.frame_index   = nxt.frame;
        res.fetch_frame   = fetch;
        res.loop_hit      = hit;
        res.error_flag    = err;
        res.player_state  = nxt.mode;
        res.going_forward = nxt.fwd;
    end

endmodule

### rtl/playback_frame_sequencer.sv
// Playback frame sequencer top level: input register, step logic, result register.
// Each accepted word passes on to the result register, which drives m_data.
// Throughput: one event word per cycle; s_ready drops only while both stages are full
// and m_ready is low.
// Reset (aresetn low, synchronous): idle, frame 0, forwards, countdown 0, both stages
// empty, registers at frame_count 1, ticks_per_frame 1, others 0.
module playback_frame_sequencer
    import pfs_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // event words
    input  logic               s_valid,
    output logic               s_ready,
    input  in_word_t           s_data,
    // result words
    output logic               m_valid,
    input  logic               m_ready,
    output out_word_t          m_data,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    cfg_t      cfg;
    pstate_t   state_reg;
    pstate_t   state_next;
    in_word_t  in_reg;
    logic      in_valid_reg;
    out_word_t out_reg;
    out_word_t out_next;
    logic      out_valid_reg;
    logic      advance;

    pfs_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pfs_step u_step (
        .cfg  (cfg),
        .cur  (state_reg),
        .word (in_reg),
        .nxt  (state_next),
        .res  (out_next)
    );

    // The word in the input stage moves on (and commits state) when the
    // result register is empty or being drained this cycle.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.mode      <= ST_IDLE;
            state_reg.frame     <= '0;
            state_reg.fwd       <= 1'b1;
            state_reg.countdown <= '0;
            in_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (advance) begin
            out_reg <= out_next;
        end
    end

endmodule

### rtl/pfs_checker.sv
// Port-level checks for the playback frame sequencer, bound to the top level.
// Depends on pfs_pkg for the result word type and player states.
module pfs_checker
    import pfs_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input out_word_t m_data
);

    // a stalled result word holds its payload
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result word changed while stalled");

    // reset empties the result stage
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a rejected command neither fetches nor reports a loop point
    a_err_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.error_flag) |-> (!m_data.fetch_frame && !m_data.loop_hit))
        else $error("rejected command fetched or hit loop");

    // a loop point leaves the player either playing or stopped
    a_hit_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.loop_hit) |->
            (m_data.player_state == ST_PLAYING || m_data.player_state == ST_STOPPED))
        else $error("loop hit in idle or paused state");

endmodule

bind playback_frame_sequencer pfs_checker u_pfs_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
